FILE: src/ffra_pkg.sv
// shared types and constants for the first-fit range allocator
// no dependencies; used by the controller, datapath and top level
package ffra_pkg;

    localparam int ADDR_W = 48;
    localparam int SIZE_W = 40;
    localparam int GRAN_W = 31;
    localparam int NEED_W = 41;
    localparam int ENTRY_W = 2 * ADDR_W;

    localparam logic [GRAN_W-1:0] GRAN_RESET = 31'd2097152;
    localparam logic [ADDR_W-1:0] ADDR_MAX = {ADDR_W{1'b1}};

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_CHUNK = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_FULL      = 2'd2,
        ST_TOO_LARGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        RS_IDX    = 2'd0,
        RS_IDX_M1 = 2'd1,
        RS_IDX_P1 = 2'd2,
        RS_PTR_M1 = 2'd3
    } t_rd_sel;

    typedef enum logic [1:0] {
        WS_SHIFT_IDX = 2'd0,
        WS_SHIFT_PTR = 2'd1,
        WS_NEW       = 2'd2,
        WS_ALLOC     = 2'd3
    } t_wr_sel;

    typedef struct packed {
        logic    load;
        logic    div_step;
        logic    round;
        logic    prep;
        logic    idx_clr;
        logic    idx_inc;
        logic    idx_dec;
        logic    ptr_load;
        logic    ptr_dec;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    fs_take_start;
        logic    fe_take_end;
        logic    grant;
        logic    set_status;
        t_status status;
        logic    publish;
        t_rd_sel rd_sel;
        logic    wr_en;
        t_wr_sel wr_sel;
    } t_dp_cmd;

    typedef struct packed {
        t_action action;
        logic    div_last;
        logic    too_large;
        logic    empty_free;
        logic    idx_ge_cnt;
        logic    idx_zero;
        logic    rm_last;
        logic    ptr_eq_idx;
        logic    full;
        logic    lt_key;
        logic    prev_adj;
        logic    next_adj;
        logic    fits;
        logic    used_up;
    } t_dp_status;

endpackage

FILE: src/first_fit_range_allocator_core.sv
// top level of the first-fit free range allocator
// depends on ffra_pkg, ffra_ctrl and ffra_datapath
//
// channel | direction | handshake                 | beat
// in      | input     | i_in_valid / o_in_ready   | i_action, i_address, i_request_size
// out     | output    | o_out_valid / i_out_ready | o_status, o_granted_address
// cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_granularity
//
// one item at a time; after the accepting edge allocate and free round the size up
// to the granularity by bit-serial restoring division before the table walk, an
// add-chunk skips that; table walks read each entry visited through the registered
// read port of the table memory, and a delete or insert shifts the entries behind
// the slot one at a time
// the result beat sits in an output register; a new input beat is taken while it
// waits, the next result waits for it to be taken
// synchronous active-low reset empties the table and loads the default granularity
module first_fit_range_allocator_core #(
    parameter int MAX_RANGES = 16,
    parameter int CHUNK_LOG2 = 31
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [ffra_pkg::GRAN_W-1:0] i_cfg_granularity,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_action,
    input  logic [ffra_pkg::ADDR_W-1:0] i_address,
    input  logic [ffra_pkg::SIZE_W-1:0] i_request_size,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_status,
    output logic [ffra_pkg::ADDR_W-1:0] o_granted_address
);
    import ffra_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_stat;

    assign o_cfg_ready = 1'b1;

    ffra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    ffra_datapath #(
        .MAX_RANGES (MAX_RANGES),
        .CHUNK_LOG2 (CHUNK_LOG2)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_granularity (i_cfg_granularity),
        .i_action          (i_action),
        .i_address         (i_address),
        .i_request_size    (i_request_size),
        .i_cmd             (dp_cmd),
        .o_stat            (dp_stat),
        .o_status          (o_status),
        .o_granted_address (o_granted_address)
    );

endmodule

FILE: src/ffra_datapath.sv
// datapath: range table memory, counters, rounding divider, result registers
// depends on ffra_pkg; driven by ffra_ctrl through t_dp_cmd
module ffra_datapath #(
    parameter int MAX_RANGES = 16,
    parameter int CHUNK_LOG2 = 31
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    input  logic [ffra_pkg::GRAN_W-1:0] i_cfg_granularity,
    input  logic [1:0]                i_action,
    input  logic [ffra_pkg::ADDR_W-1:0] i_address,
    input  logic [ffra_pkg::SIZE_W-1:0] i_request_size,
    input  ffra_pkg::t_dp_cmd         i_cmd,
    output ffra_pkg::t_dp_status      o_stat,
    output logic [1:0]                o_status,
    output logic [ffra_pkg::ADDR_W-1:0] o_granted_address
);
    import ffra_pkg::*;

    localparam int IW = $clog2(MAX_RANGES);
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int DW = $clog2(NEED_W);
    localparam logic [NEED_W-1:0] CHUNK_SIZE = NEED_W'(1) << CHUNK_LOG2;

    logic [ENTRY_W-1:0] mem [MAX_RANGES];
    logic [ENTRY_W-1:0] r_rd;

    logic [GRAN_W-1:0] r_gran;
    t_action           r_action;
    logic [ADDR_W-1:0] r_addr;
    logic [NEED_W-1:0] r_sum;
    logic [NEED_W-1:0] r_dvd;
    logic [GRAN_W-1:0] r_rem;
    logic [DW-1:0]     r_dcnt;
    logic [NEED_W-1:0] r_need;
    logic [ADDR_W-1:0] r_fs;
    logic [ADDR_W-1:0] r_fe;
    logic [CW-1:0]     r_idx;
    logic [CW-1:0]     r_ptr;
    logic [CW-1:0]     r_count;
    t_status           r_status;
    logic [ADDR_W-1:0] r_grant;
    t_status           r_out_status;
    logic [ADDR_W-1:0] r_out_grant;

    logic [GRAN_W-1:0] gran_eff;
    logic [GRAN_W:0]   div_trial;
    logic [ADDR_W:0]   fe_sum;
    logic [ADDR_W-1:0] fe_calc;
    logic [ADDR_W-1:0] rd_start;
    logic [ADDR_W-1:0] rd_end;
    logic [ADDR_W:0]   new_start;
    logic [CW-1:0]     rd_addr;
    logic [CW-1:0]     wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    assign gran_eff  = (r_gran == '0) ? GRAN_W'(1) : r_gran;
    assign div_trial = {r_rem, r_dvd[NEED_W-1]};
    assign rd_start  = r_rd[ENTRY_W-1:ADDR_W];
    assign rd_end    = r_rd[ADDR_W-1:0];
    assign new_start = {1'b0, rd_start} + (ADDR_W+1)'(r_need);

    always_comb begin
        if (r_action == ACT_CHUNK) begin
            fe_sum = {1'b0, r_addr} + (ADDR_W+1)'(CHUNK_SIZE);
        end else begin
            fe_sum = {1'b0, r_addr} + (ADDR_W+1)'(r_need);
        end
        fe_calc = fe_sum[ADDR_W] ? ADDR_MAX : fe_sum[ADDR_W-1:0];
    end

    always_comb begin
        unique case (i_cmd.rd_sel)
            RS_IDX:    rd_addr = r_idx;
            RS_IDX_M1: rd_addr = r_idx - CW'(1);
            RS_IDX_P1: rd_addr = r_idx + CW'(1);
            RS_PTR_M1: rd_addr = r_ptr - CW'(1);
            default:   rd_addr = r_idx;
        endcase
        unique case (i_cmd.wr_sel)
            WS_SHIFT_IDX: begin
                wr_addr = r_idx;
                wr_data = r_rd;
            end
            WS_SHIFT_PTR: begin
                wr_addr = r_ptr;
                wr_data = r_rd;
            end
            WS_NEW: begin
                wr_addr = r_idx;
                wr_data = {r_fs, r_fe};
            end
            WS_ALLOC: begin
                wr_addr = r_idx;
                wr_data = {new_start[ADDR_W-1:0], rd_end};
            end
            default: begin
                wr_addr = r_idx;
                wr_data = r_rd;
            end
        endcase
    end

    // table storage, no reset: only entries below the count are ever used
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[wr_addr[IW-1:0]] <= wr_data;
        end
        r_rd <= mem[rd_addr[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gran  <= GRAN_RESET;
            r_count <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_gran <= i_cfg_granularity;
            end
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= t_action'(i_action);
            r_addr   <= i_address;
            r_sum    <= NEED_W'(i_request_size) + NEED_W'(gran_eff) - NEED_W'(1);
            r_dvd    <= NEED_W'(i_request_size) + NEED_W'(gran_eff) - NEED_W'(1);
            r_rem    <= '0;
            r_dcnt   <= '0;
            r_status <= ST_OK;
            r_grant  <= '0;
        end
        // restoring remainder, one dividend bit per step
        if (i_cmd.div_step) begin
            if (div_trial >= {1'b0, gran_eff}) begin
                r_rem <= GRAN_W'(div_trial - {1'b0, gran_eff});
            end else begin
                r_rem <= div_trial[GRAN_W-1:0];
            end
            r_dvd  <= r_dvd << 1;
            r_dcnt <= r_dcnt + DW'(1);
        end
        if (i_cmd.round) begin
            r_need <= r_sum - NEED_W'(r_rem);
        end
        if (i_cmd.prep) begin
            r_fs <= r_addr;
            r_fe <= fe_calc;
        end
        if (i_cmd.fs_take_start) begin
            r_fs <= rd_start;
        end
        if (i_cmd.fe_take_end) begin
            r_fe <= rd_end;
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + CW'(1);
        end else if (i_cmd.idx_dec) begin
            r_idx <= r_idx - CW'(1);
        end
        if (i_cmd.ptr_load) begin
            r_ptr <= r_count;
        end else if (i_cmd.ptr_dec) begin
            r_ptr <= r_ptr - CW'(1);
        end
        if (i_cmd.grant) begin
            r_grant <= rd_start;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.publish) begin
            r_out_status <= r_status;
            r_out_grant  <= r_grant;
        end
    end

    always_comb begin
        o_stat.action     = r_action;
        o_stat.div_last   = (r_dcnt == DW'(NEED_W - 1));
        o_stat.too_large  = (r_need > CHUNK_SIZE);
        o_stat.empty_free = (fe_calc <= r_addr);
        o_stat.idx_ge_cnt = (r_idx >= r_count);
        o_stat.idx_zero   = (r_idx == '0);
        o_stat.rm_last    = (({1'b0, r_idx} + (CW+1)'(1)) >= {1'b0, r_count});
        o_stat.ptr_eq_idx = (r_ptr == r_idx);
        o_stat.full       = (r_count == CW'(MAX_RANGES));
        o_stat.lt_key     = (rd_start < r_fs);
        o_stat.prev_adj   = (rd_end == r_fs);
        o_stat.next_adj   = (rd_start == r_fe);
        o_stat.fits       = ((rd_end - rd_start) >= ADDR_W'(r_need));
        o_stat.used_up    = (new_start >= {1'b0, rd_end});
    end

    assign o_status          = r_out_status;
    assign o_granted_address = r_out_grant;

endmodule

FILE: src/ffra_ctrl.sv
// controller: sequences rounding, table scans, shifts and the result beat
// depends on ffra_pkg; commands ffra_datapath, reads its status
module ffra_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  ffra_pkg::t_dp_status i_stat,
    output ffra_pkg::t_dp_cmd    o_cmd
);
    import ffra_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_DIV, S_ROUND, S_PREP,
        S_FIND_RD, S_FIND_CK, S_AFTER_FIND,
        S_PREV_RD, S_PREV_CK, S_NEXT, S_NEXT_CK,
        S_RM_RD, S_RM_WR,
        S_INS, S_INS_RD, S_INS_WR,
        S_AL_RD, S_AL_CK, S_DONE
    } t_state;

    // which step of the item a shared scan or shift returns to
    typedef enum logic [2:0] {
        PH_ALLOC, PH_FREE_A, PH_FREE_B, PH_FREE_C, PH_CHUNK
    } t_phase;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.status = ST_OK;
        o_cmd.rd_sel = RS_IDX;
        o_cmd.wr_sel = WS_NEW;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                unique case (i_stat.action)
                    ACT_ALLOC, ACT_FREE: n_state = S_DIV;
                    ACT_CHUNK:           n_state = S_PREP;
                    default:             n_state = S_DONE;
                endcase
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_state     = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep    = 1'b1;
                o_cmd.idx_clr = 1'b1;
                unique case (i_stat.action)
                    ACT_ALLOC: begin
                        n_phase = PH_ALLOC;
                        if (i_stat.too_large) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_TOO_LARGE;
                            n_state          = S_DONE;
                        end else begin
                            n_state = S_AL_RD;
                        end
                    end
                    ACT_FREE: begin
                        n_phase = PH_FREE_A;
                        n_state = i_stat.empty_free ? S_DONE : S_FIND_RD;
                    end
                    ACT_CHUNK: begin
                        n_phase = PH_CHUNK;
                        n_state = S_FIND_RD;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_FIND_RD: begin
                o_cmd.rd_sel = RS_IDX;
                n_state = i_stat.idx_ge_cnt ? S_AFTER_FIND : S_FIND_CK;
            end
            S_FIND_CK: begin
                if (i_stat.lt_key) begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_FIND_RD;
                end else begin
                    n_state = S_AFTER_FIND;
                end
            end
            S_AFTER_FIND: begin
                unique case (r_phase)
                    PH_FREE_A: n_state = i_stat.idx_zero ? S_NEXT : S_PREV_RD;
                    PH_FREE_B: n_state = S_NEXT;
                    PH_FREE_C, PH_CHUNK: n_state = S_INS;
                    default:   n_state = S_DONE;
                endcase
            end
            S_PREV_RD: begin
                o_cmd.rd_sel = RS_IDX_M1;
                n_state      = S_PREV_CK;
            end
            S_PREV_CK: begin
                // lower neighbor ends at the freed start: absorb it
                if (i_stat.prev_adj) begin
                    o_cmd.fs_take_start = 1'b1;
                    o_cmd.idx_dec       = 1'b1;
                    n_phase             = PH_FREE_B;
                    n_state             = S_RM_RD;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                o_cmd.rd_sel = RS_IDX;
                if (i_stat.idx_ge_cnt) begin
                    o_cmd.idx_clr = 1'b1;
                    n_phase       = PH_FREE_C;
                    n_state       = S_FIND_RD;
                end else begin
                    n_state = S_NEXT_CK;
                end
            end
            S_NEXT_CK: begin
                n_phase = PH_FREE_C;
                if (i_stat.next_adj) begin
                    o_cmd.fe_take_end = 1'b1;
                    n_state           = S_RM_RD;
                end else begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_FIND_RD;
                end
            end
            S_RM_RD: begin
                o_cmd.rd_sel = RS_IDX_P1;
                if (i_stat.rm_last) begin
                    o_cmd.cnt_dec = 1'b1;
                    if (r_phase == PH_ALLOC) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.idx_clr = 1'b1;
                        n_state       = S_FIND_RD;
                    end
                end else begin
                    n_state = S_RM_WR;
                end
            end
            S_RM_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = WS_SHIFT_IDX;
                o_cmd.idx_inc = 1'b1;
                n_state       = S_RM_RD;
            end
            S_INS: begin
                if (i_stat.full) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_FULL;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.ptr_load = 1'b1;
                    n_state        = S_INS_RD;
                end
            end
            S_INS_RD: begin
                o_cmd.rd_sel = RS_PTR_M1;
                if (i_stat.ptr_eq_idx) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_sel  = WS_NEW;
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    n_state = S_INS_WR;
                end
            end
            S_INS_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = WS_SHIFT_PTR;
                o_cmd.ptr_dec = 1'b1;
                n_state       = S_INS_RD;
            end
            S_AL_RD: begin
                o_cmd.rd_sel = RS_IDX;
                if (i_stat.idx_ge_cnt) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_NO_FIT;
                    n_state          = S_DONE;
                end else begin
                    n_state = S_AL_CK;
                end
            end
            S_AL_CK: begin
                if (i_stat.fits) begin
                    o_cmd.grant = 1'b1;
                    if (i_stat.used_up) begin
                        n_state = S_RM_RD;
                    end else begin
                        o_cmd.wr_en  = 1'b1;
                        o_cmd.wr_sel = WS_ALLOC;
                        n_state      = S_DONE;
                    end
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_AL_RD;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_ALLOC;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: src/ffra_checker.sv
// port-level checks for the range allocator core
// depends on ffra_pkg; bound to first_fit_range_allocator_core below
module ffra_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [1:0]                  o_status,
    input logic [ffra_pkg::ADDR_W-1:0] o_granted_address
);
    import ffra_pkg::*;

    // only a successful allocation carries an address
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> o_granted_address == '0)
        else $error("granted address nonzero on a failed result");

    // one item in flight: no input beat right after one is taken
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while an item is in progress");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_granted_address))
        else $error("stalled result beat changed");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind first_fit_range_allocator_core ffra_checker u_ffra_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_ready        (o_in_ready),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_status          (o_status),
    .o_granted_address (o_granted_address)
);

FILE: test/tb_first_fit_range_allocator_core.sv
// testbench for first_fit_range_allocator_core: directed corner items, then random
// allocate/free/add-chunk/no-op traffic under several granularities, checked by a scoreboard
// depends on ffra_pkg and the first_fit_range_allocator_core RTL
module tb_first_fit_range_allocator_core;
    import ffra_pkg::*;

    localparam int          TABLE_DEPTH = 16;
    localparam logic [63:0] CHUNK_BYTES = 64'd1 << 31;
    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          SETTLE_CYCLES = 200;

    class alloc_scoreboard;
        typedef struct {
            t_status     st;
            logic [47:0] addr;
        } t_result;

        logic [47:0] rng_lo[TABLE_DEPTH];
        logic [47:0] rng_hi[TABLE_DEPTH];
        int          count;
        logic [30:0] gran;
        t_result     pending[$];
        int          errors;
        int          checked;
        int          status_seen[4];

        function new();
            count = 0;
            gran = GRAN_RESET;
            errors = 0;
            checked = 0;
            foreach (status_seen[k]) status_seen[k] = 0;
        endfunction

        function logic [63:0] round_up(logic [39:0] sz);
            logic [63:0] g;
            g = (gran == 0) ? 64'd1 : 64'(gran);
            return ((64'(sz) + g - 1) / g) * g;
        endfunction

        function logic [47:0] clip(logic [47:0] base, logic [63:0] len);
            logic [63:0] e;
            e = 64'(base) + len;
            return (e > 64'(ADDR_MAX)) ? ADDR_MAX : e[47:0];
        endfunction

        function int find_slot(logic [47:0] key);
            int i;
            i = 0;
            while (i < count && rng_lo[i] < key) i++;
            return i;
        endfunction

        function void drop_at(int i);
            for (int j = i; j < count - 1; j++) begin
                rng_lo[j] = rng_lo[j+1];
                rng_hi[j] = rng_hi[j+1];
            end
            count--;
        endfunction

        function bit put_at(int i, logic [47:0] s, logic [47:0] e);
            if (count >= TABLE_DEPTH) return 0;
            for (int j = count; j > i; j--) begin
                rng_lo[j] = rng_lo[j-1];
                rng_hi[j] = rng_hi[j-1];
            end
            rng_lo[i] = s;
            rng_hi[i] = e;
            count++;
            return 1;
        endfunction

        // predicts one accepted beat; returns the expected grant address
        function logic [47:0] note_input(t_action act, logic [47:0] ad, logic [39:0] sz);
            t_result     r;
            logic [63:0] need;
            logic [47:0] fs;
            logic [47:0] fe;
            int          i;
            r.st = ST_OK;
            r.addr = '0;
            case (act)
                ACT_ALLOC: begin
                    need = round_up(sz);
                    if (need > CHUNK_BYTES) begin
                        r.st = ST_TOO_LARGE;
                    end else begin
                        r.st = ST_NO_FIT;
                        for (i = 0; i < count; i++) begin
                            if (64'(rng_hi[i]) - 64'(rng_lo[i]) >= need) begin
                                r.addr = rng_lo[i];
                                rng_lo[i] = rng_lo[i] + need[47:0];
                                if (rng_lo[i] >= rng_hi[i]) drop_at(i);
                                r.st = ST_OK;
                                break;
                            end
                        end
                    end
                end
                ACT_FREE: begin
                    fs = ad;
                    fe = clip(ad, round_up(sz));
                    if (fe > fs) begin
                        i = find_slot(fs);
                        if (i > 0 && rng_hi[i-1] == fs) begin
                            fs = rng_lo[i-1];
                            drop_at(i - 1);
                            i = find_slot(fs);
                        end
                        if (i < count && rng_lo[i] == fe) begin
                            fe = rng_hi[i];
                            drop_at(i);
                        end
                        if (!put_at(find_slot(fs), fs, fe)) r.st = ST_FULL;
                    end
                end
                ACT_CHUNK: begin
                    if (!put_at(find_slot(ad), ad, clip(ad, CHUNK_BYTES))) r.st = ST_FULL;
                end
                default: ;
            endcase
            status_seen[r.st]++;
            pending.insert(pending.size(), r);
            return r.addr;
        endfunction

        function void check_result(logic [1:0] st, logic [47:0] addr);
            t_result r;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: status %0d addr %h", st, addr);
                return;
            end
            r = pending.pop_front();
            if (st !== r.st || addr !== r.addr) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch on result %0d: status exp %0d got %0d, addr exp %h got %h",
                             checked, r.st, st, r.addr, addr);
            end
        endfunction
    endclass

    typedef struct {
        logic [47:0] addr;
        logic [39:0] size;
    } t_grant;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [30:0] cfg_gran = '0;
    logic        in_valid = 1'b0;
    logic [1:0]  in_action = '0;
    logic [47:0] in_address = '0;
    logic [39:0] in_size = '0;
    logic        out_ready = 1'b0;
    logic        o_cfg_ready;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic [47:0] o_granted_address;

    alloc_scoreboard sb = new();
    t_grant          live_grants[$];
    bit              idle_en = 1'b1;
    bit              hold_req = 1'b0;
    int              hold_left = 0;
    int              stall_left = 0;
    int              quiet_cycles = 0;
    int              items_sent = 0;
    int              cfg_writes = 0;

    first_fit_range_allocator_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_granularity (cfg_gran),
        .i_in_valid        (in_valid),
        .o_in_ready        (o_in_ready),
        .i_action          (in_action),
        .i_address         (in_address),
        .i_request_size    (in_size),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (out_ready),
        .o_status          (o_status),
        .o_granted_address (o_granted_address)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // result side: checks beats and stalls in bursts or one long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && out_ready) sb.check_result(o_status, o_granted_address);
            if (hold_req && hold_left == 0) begin
                hold_left = 500;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 9) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog: counts cycles with work outstanding but no beat moving
    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) || (cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else if (in_valid || cfg_valid || sb.pending.size() > 0)
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", quiet_cycles);
            $display("first_fit_range_allocator_core regression: fail");
            $finish;
        end
    end

    task automatic send_item(t_action act, logic [47:0] ad, logic [39:0] sz);
        logic [47:0] granted;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_action <= act;
        in_address <= ad;
        in_size <= sz;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        granted = sb.note_input(act, ad, sz);
        items_sent++;
        if (act == ACT_ALLOC && sb.pending[$].st == ST_OK && sb.round_up(sz) != 0)
            live_grants.insert(live_grants.size(), '{granted, sz});
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() > 0) @(posedge i_clk);
    endtask

    task automatic write_granularity(logic [30:0] g);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_gran <= g;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        sb.gran = g;
        cfg_writes++;
    endtask

    task automatic random_item();
        int          pick;
        int          k;
        logic [63:0] g;
        logic [63:0] sz;
        t_grant      gr;
        pick = $urandom_range(0, 99);
        g = (sb.gran == 0) ? 64'd1 : 64'(sb.gran);
        if (pick < 38) begin
            case ($urandom_range(0, 9))
                0, 1:    sz = {$urandom, $urandom};
                2, 3:    sz = 64'($urandom_range(0, 4096));
                default: begin
                    sz = g * 64'($urandom_range(0, 3));
                    if (sz > 0) sz = sz - 64'($urandom_range(0, 1));
                end
            endcase
            send_item(ACT_ALLOC, 48'($urandom), sz[39:0]);
        end else if (pick < 68 && live_grants.size() > 0) begin
            k = $urandom_range(0, live_grants.size() - 1);
            gr = live_grants[k];
            live_grants.delete(k);
            send_item(ACT_FREE, gr.addr, gr.size);
        end else if (pick < 78) begin
            send_item(ACT_FREE, 48'({$urandom, $urandom}), 40'({$urandom, $urandom}));
        end else if (pick < 95) begin
            if ($urandom_range(0, 9) == 0)
                send_item(ACT_CHUNK, 48'({$urandom, $urandom}), 40'({$urandom, $urandom}));
            else
                send_item(ACT_CHUNK, 48'($urandom_range(0, 31)) << 31, 40'($urandom));
        end else begin
            send_item(ACT_NONE, 48'({$urandom, $urandom}), 40'({$urandom, $urandom}));
        end
    endtask

    initial begin
        logic [30:0] gran_plan[7];
        gran_plan = '{GRAN_RESET, 31'd0, 31'd1, 31'h4000_0000, 31'h7fff_ffff, 31'd4096, 31'd0};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table corners
        send_item(ACT_ALLOC, '0, 40'd1);
        send_item(ACT_ALLOC, '0, 40'd0);
        send_item(ACT_NONE, ADDR_MAX, {40{1'b1}});
        send_item(ACT_FREE, 48'h1234_0000, 40'd0);
        // fill the table with non-adjacent chunks, then overflow it
        for (int k = 0; k < TABLE_DEPTH; k++) send_item(ACT_CHUNK, 48'(k) << 32, '0);
        send_item(ACT_CHUNK, 48'h7_0000_0000_00, '0);
        send_item(ACT_FREE, 48'h8000_0000_0000, 40'd5);
        send_item(ACT_FREE, 48'h8000_0000, 40'd1);
        send_item(ACT_ALLOC, '0, {40{1'b1}});
        send_item(ACT_ALLOC, '0, 40'h80_0000_0000 >> 8);
        send_item(ACT_ALLOC, '0, 40'd0);
        send_item(ACT_FREE, ADDR_MAX - 48'd5, 40'd100);
        send_item(ACT_CHUNK, ADDR_MAX, '0);

        for (int p = 0; p < 7; p++) begin
            if (p == 0) begin
                wait_drained();
                repeat (SETTLE_CYCLES) @(posedge i_clk);
            end else begin
                write_granularity(p == 6 ? 31'($urandom) : gran_plan[p]);
            end
            if (p == 6) idle_en = 1'b0;
            for (int n = 0; n < 220; n++) begin
                if (p == 2 && n == 40) hold_req = 1'b1;
                random_item();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.pending.size() > 0) sb.errors++;
        $display("covered %0d items over %0d granularity settings: ok %0d, no-fit %0d",
                 items_sent, cfg_writes + 1, sb.status_seen[ST_OK], sb.status_seen[ST_NO_FIT]);
        $display("table-full %0d, too-large %0d, mismatches %0d",
                 sb.status_seen[ST_FULL], sb.status_seen[ST_TOO_LARGE], sb.errors);
        if (sb.errors == 0) begin
            $display("first_fit_range_allocator_core regression: pass");
        end else begin
            $display("first_fit_range_allocator_core regression: fail");
        end
        $finish;
    end
endmodule
